### src/ide_pkg.sv
`timescale 1ns / 1ps

package ide_pkg;

  // Field widths fixed by the request and result formats
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 4;
  localparam int DATA_W  = 64;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Request codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_ERASE      = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOB  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } rsp_t;

endpackage

### src/ide_core.sv
`timescale 1ns / 1ps

module ide_core #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          upd,
  input  ide_pkg::req_t req,
  output ide_pkg::rsp_t rsp
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > ide_pkg::POS_W) ? CW : ide_pkg::POS_W;

  logic signed [ide_pkg::DATA_W-1:0] slots_r   [DEPTH];
  logic signed [ide_pkg::DATA_W-1:0] slots_nxt [DEPTH];
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic [CW-1:0]   cnt_m1;
  logic [CMPW-1:0] pos_c;
  logic [CMPW-1:0] cnt_c;
  logic [CMPW-1:0] idx_c;
  logic            full;
  logic            empty;
  logic            pos_oob;
  logic            ins_en;
  logic            rem_en;
  logic signed [ide_pkg::DATA_W-1:0] popped;
  logic [ide_pkg::STAT_W-1:0] status;

  assign cnt_m1  = cnt_r - CW'(1);
  assign pos_c   = CMPW'(req.position);
  assign cnt_c   = CMPW'(cnt_r);
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pos_oob = (pos_c >= cnt_c);

  // Decode the request into at most one insert or remove at a single index
  always_comb begin
    ins_en  = 1'b0;
    rem_en  = 1'b0;
    idx_c   = '0;
    popped  = '0;
    status  = ide_pkg::ST_OK;
    cnt_nxt = cnt_r;
    case (req.func)
      ide_pkg::FN_PUSH_FRONT: begin
        if (full) begin
          status = ide_pkg::ST_FULL;
        end else begin
          ins_en = 1'b1;
        end
      end
      ide_pkg::FN_PUSH_BACK: begin
        if (full) begin
          status = ide_pkg::ST_FULL;
        end else begin
          ins_en = 1'b1;
          idx_c  = cnt_c;
        end
      end
      ide_pkg::FN_POP_FRONT: begin
        if (!empty) begin
          rem_en = 1'b1;
          popped = slots_r[0];
        end
      end
      ide_pkg::FN_POP_BACK: begin
        // Dropping the tail needs no move, only the count
        if (!empty) begin
          rem_en = 1'b1;
          idx_c  = CMPW'(cnt_m1);
          popped = slots_r[cnt_m1[IW-1:0]];
        end
      end
      ide_pkg::FN_INSERT: begin
        if (pos_oob) begin
          status = ide_pkg::ST_OOB;
        end else if (full) begin
          status = ide_pkg::ST_FULL;
        end else begin
          ins_en = 1'b1;
          idx_c  = pos_c;
        end
      end
      ide_pkg::FN_ERASE: begin
        if (pos_oob) begin
          status = ide_pkg::ST_OOB;
        end else begin
          rem_en = 1'b1;
          idx_c  = pos_c;
        end
      end
      default: begin
      end
    endcase
    if (ins_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (rem_en) begin
      cnt_nxt = cnt_m1;
    end
  end

  // Each slot compares its own position with the index: shift, load or hold
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    localparam logic [CMPW-1:0] ME = CMPW'(i);
    logic signed [ide_pkg::DATA_W-1:0] below;
    logic signed [ide_pkg::DATA_W-1:0] above;

    if (i == 0) begin : g_lo
      assign below = slots_r[0];
    end else begin : g_mid
      assign below = slots_r[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi
      assign above = slots_r[i];
    end else begin : g_up
      assign above = slots_r[i+1];
    end

    always_comb begin
      slots_nxt[i] = slots_r[i];
      if (ins_en && (ME == idx_c)) begin
        slots_nxt[i] = req.value;
      end else if (ins_en && (ME > idx_c)) begin
        slots_nxt[i] = below;
      end else if (rem_en && (ME >= idx_c)) begin
        slots_nxt[i] = above;
      end
    end
  end

  // Element storage, no reset needed
  always_ff @(posedge clk) begin
    if (upd) begin
      slots_r <= slots_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (upd) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign rsp.popped   = popped;
  assign rsp.status   = status;
  assign rsp.count    = ide_pkg::COUNT_W'(cnt_nxt);
  assign rsp.is_empty = (cnt_nxt == '0);

endmodule

### src/indexed_deque_engine.sv
`timescale 1ns / 1ps

// Indexed deque of up to DEPTH signed 64-bit elements with push/pop at either
// end and insert/erase at an index. Every request is registered on entry,
// resolved by per-slot shift logic, and its result lands in an output register,
// so a new transaction is accepted every cycle while the output register is free.
// Throughput is one transaction
// per cycle; it drops only while out_stall holds a result in the output
// register. The slot array needs no clearing after reset.
module indexed_deque_engine #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ide_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ide_pkg::rsp_t out_data
);

  logic          req_valid_r;
  ide_pkg::req_t req_r;
  logic          out_valid_r;
  ide_pkg::rsp_t out_data_r;
  ide_pkg::rsp_t rsp;
  logic          out_free;
  logic          advance;

  // Pipeline flow control
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = req_valid_r && out_free;
  assign in_stall = req_valid_r && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_data;
    end
  end

  ide_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (advance),
    .req   (req_r),
    .rsp   (rsp)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/ide_checker.sv
`timescale 1ns / 1ps

module ide_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input ide_pkg::req_t in_data,
  input logic          out_valid,
  input logic          out_stall,
  input ide_pkg::rsp_t out_data
);

  // A result held by the consumer stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result transaction changed while stalled");

  // Back-pressure on the input only comes from a stalled, full output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Rejected requests never return an element
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ide_pkg::ST_OK) |-> out_data.popped == '0)
    else $error("error result carries a popped value");

  // An accepted request shows up as a result when the output is not stalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !out_stall ##1 !out_stall |-> out_valid)
    else $error("accepted transaction produced no result");

  // No result appears out of an empty pipe
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && !in_stall) ##1 !out_valid |=> !out_valid)
    else $error("result without a request");

endmodule

bind indexed_deque_engine ide_checker u_ide_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### test/tb_indexed_deque_engine.sv
`timescale 1ns / 1ps

module tb_indexed_deque_engine;

  localparam int DEPTH = 16;
  localparam int PHASE_ITEMS = 131;
  localparam int SETTLE_CYCLES = 10;

  // Codes the block does not decode; they must leave the list alone
  localparam logic [ide_pkg::FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [ide_pkg::FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  localparam logic signed [ide_pkg::DATA_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ide_pkg::DATA_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [ide_pkg::DATA_W-1:0] VAL_NEG1 = 64'shFFFF_FFFF_FFFF_FFFF;
  localparam logic signed [ide_pkg::DATA_W-1:0] VAL_ALT0 = 64'sh5555_5555_5555_5555;
  localparam logic signed [ide_pkg::DATA_W-1:0] VAL_ALT1 = 64'shAAAA_AAAA_AAAA_AAAA;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX, BURST_NOISE} burst_t;

  // One row of the opening sequence: request plus an optional hand-written result
  typedef struct packed {
    ide_pkg::req_t req;
    logic hand_checked;
    ide_pkg::rsp_t rsp;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ide_pkg::req_t in_data;
  logic out_valid;
  logic out_stall;
  ide_pkg::rsp_t out_data;

  // Shadow copy of the list contents
  logic signed [ide_pkg::DATA_W-1:0] shadow_slots [DEPTH];
  int shadow_fill;

  ide_pkg::rsp_t pending_rsps [$];
  ide_pkg::rsp_t oldest_rsp;
  int mismatches;
  int idle_pct;
  int stall_pct;

  script_row_t opening_script [0:20] = '{
    '{'{ide_pkg::FN_POP_FRONT, 4'd0, 64'sd0}, 1'b1, '{64'sd0, ide_pkg::ST_OK, 5'd0, 1'b1}},
    '{'{ide_pkg::FN_POP_BACK, 4'd15, VAL_MAX}, 1'b1, '{64'sd0, ide_pkg::ST_OK, 5'd0, 1'b1}},
    '{'{ide_pkg::FN_ERASE, 4'd0, 64'sd0}, 1'b1, '{64'sd0, ide_pkg::ST_OOB, 5'd0, 1'b1}},
    '{'{ide_pkg::FN_INSERT, 4'd0, 64'sd5}, 1'b1, '{64'sd0, ide_pkg::ST_OOB, 5'd0, 1'b1}},
    '{'{FN_SPARE_6, 4'd15, VAL_NEG1}, 1'b1, '{64'sd0, ide_pkg::ST_OK, 5'd0, 1'b1}},
    '{'{FN_SPARE_7, 4'd9, VAL_MIN}, 1'b1, '{64'sd0, ide_pkg::ST_OK, 5'd0, 1'b1}},
    '{'{ide_pkg::FN_PUSH_BACK, 4'd0, VAL_MAX}, 1'b1, '{64'sd0, ide_pkg::ST_OK, 5'd1, 1'b0}},
    '{'{ide_pkg::FN_PUSH_FRONT, 4'd15, VAL_MIN}, 1'b1, '{64'sd0, ide_pkg::ST_OK, 5'd2, 1'b0}},
    '{'{ide_pkg::FN_INSERT, 4'd1, VAL_NEG1}, 1'b1, '{64'sd0, ide_pkg::ST_OK, 5'd3, 1'b0}},
    '{'{ide_pkg::FN_INSERT, 4'd15, VAL_ALT0}, 1'b1, '{64'sd0, ide_pkg::ST_OOB, 5'd3, 1'b0}},
    '{'{ide_pkg::FN_ERASE, 4'd3, VAL_ALT1}, 1'b1, '{64'sd0, ide_pkg::ST_OOB, 5'd3, 1'b0}},
    '{'{ide_pkg::FN_POP_BACK, 4'd0, 64'sd0}, 1'b1, '{VAL_MAX, ide_pkg::ST_OK, 5'd2, 1'b0}},
    '{'{ide_pkg::FN_INSERT, 4'd0, VAL_ALT0}, 1'b0, '0},
    '{'{ide_pkg::FN_PUSH_FRONT, 4'd10, VAL_ALT1}, 1'b0, '0},
    '{'{ide_pkg::FN_ERASE, 4'd1, 64'sd0}, 1'b0, '0},
    '{'{ide_pkg::FN_POP_FRONT, 4'd5, VAL_NEG1}, 1'b0, '0},
    '{'{ide_pkg::FN_PUSH_BACK, 4'd6, 64'sd1}, 1'b0, '0},
    '{'{ide_pkg::FN_ERASE, 4'd2, 64'sd0}, 1'b0, '0},
    '{'{ide_pkg::FN_POP_FRONT, 4'd0, 64'sd0}, 1'b0, '0},
    '{'{ide_pkg::FN_POP_BACK, 4'd0, 64'sd0}, 1'b0, '0},
    '{'{ide_pkg::FN_POP_BACK, 4'd0, 64'sd0}, 1'b1, '{64'sd0, ide_pkg::ST_OK, 5'd0, 1'b1}}
  };

  indexed_deque_engine #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // Remove one element, close the gap and clear the freed slot
  function automatic logic signed [ide_pkg::DATA_W-1:0] take_element(input int idx);
    logic signed [ide_pkg::DATA_W-1:0] taken;
    taken = shadow_slots[idx];
    for (int i = idx; i + 1 < shadow_fill; i++) shadow_slots[i] = shadow_slots[i + 1];
    shadow_fill--;
    shadow_slots[shadow_fill] = '0;
    return taken;
  endfunction

  // Open a hole at idx and write the new element there
  function automatic void place_element(input int idx,
                                        input logic signed [ide_pkg::DATA_W-1:0] v);
    for (int i = shadow_fill; i > idx; i--) shadow_slots[i] = shadow_slots[i - 1];
    shadow_slots[idx] = v;
    shadow_fill++;
  endfunction

  // Apply one request to the shadow list and return the result it yields
  function automatic ide_pkg::rsp_t deque_apply(input ide_pkg::req_t r);
    ide_pkg::rsp_t res;
    res = '0;
    res.status = ide_pkg::ST_OK;
    case (r.func)
      ide_pkg::FN_PUSH_FRONT: begin
        if (shadow_fill >= DEPTH) res.status = ide_pkg::ST_FULL;
        else place_element(0, r.value);
      end
      ide_pkg::FN_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) res.status = ide_pkg::ST_FULL;
        else place_element(shadow_fill, r.value);
      end
      ide_pkg::FN_POP_FRONT: begin
        if (shadow_fill > 0) res.popped = take_element(0);
      end
      ide_pkg::FN_POP_BACK: begin
        if (shadow_fill > 0) res.popped = take_element(shadow_fill - 1);
      end
      ide_pkg::FN_INSERT: begin
        if (int'(r.position) >= shadow_fill) res.status = ide_pkg::ST_OOB;
        else if (shadow_fill >= DEPTH) res.status = ide_pkg::ST_FULL;
        else place_element(int'(r.position), r.value);
      end
      ide_pkg::FN_ERASE: begin
        if (int'(r.position) >= shadow_fill) res.status = ide_pkg::ST_OOB;
        else void'(take_element(int'(r.position)));
      end
      default: ;
    endcase
    res.count = ide_pkg::COUNT_W'(shadow_fill);
    res.is_empty = (shadow_fill == 0);
    return res;
  endfunction

  // Element values lean on the extremes now and then
  function automatic logic signed [ide_pkg::DATA_W-1:0] draw_value();
    case ($urandom_range(7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return VAL_NEG1;
      4: return ide_pkg::DATA_W'($signed($urandom_range(200)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic ide_pkg::req_t draw_request(input burst_t kind);
    ide_pkg::req_t r;
    r.value = draw_value();
    case (kind)
      BURST_FILL: begin
        case ($urandom_range(2))
          0: r.func = ide_pkg::FN_PUSH_FRONT;
          1: r.func = ide_pkg::FN_PUSH_BACK;
          default: r.func = ide_pkg::FN_INSERT;
        endcase
      end
      BURST_DRAIN: begin
        case ($urandom_range(2))
          0: r.func = ide_pkg::FN_POP_FRONT;
          1: r.func = ide_pkg::FN_POP_BACK;
          default: r.func = ide_pkg::FN_ERASE;
        endcase
      end
      BURST_MIX: r.func = ide_pkg::FUNC_W'($urandom_range(5));
      default: r.func = ide_pkg::FUNC_W'($urandom_range(7));
    endcase
    // Mostly a legal index, sometimes anything the field holds
    if (kind != BURST_NOISE && shadow_fill > 0 && $urandom_range(7) != 0)
      r.position = ide_pkg::POS_W'($urandom_range(shadow_fill - 1));
    else
      r.position = ide_pkg::POS_W'($urandom_range(15));
    return r;
  endfunction

  // Drive one transaction, wait for acceptance, then record what should come back
  task automatic send_request(input ide_pkg::req_t r, input logic hand_checked,
                              input ide_pkg::rsp_t hand_rsp);
    ide_pkg::rsp_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = deque_apply(r);
    pending_rsps.push_back(hand_checked ? hand_rsp : predicted);
  endtask

  task automatic flag_mismatch(input string field, input logic [ide_pkg::DATA_W-1:0] want,
                               input logic [ide_pkg::DATA_W-1:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field,
             $signed(want), $signed(got));
    mismatches++;
  endtask

  // Result side: random back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsps.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_data);
        mismatches++;
      end else begin
        oldest_rsp = pending_rsps.pop_front();
        if (out_data.popped !== oldest_rsp.popped)
          flag_mismatch("popped", oldest_rsp.popped, out_data.popped);
        if (out_data.status !== oldest_rsp.status)
          flag_mismatch("status", ide_pkg::DATA_W'(oldest_rsp.status),
                        ide_pkg::DATA_W'(out_data.status));
        if (out_data.count !== oldest_rsp.count)
          flag_mismatch("count", ide_pkg::DATA_W'(oldest_rsp.count),
                        ide_pkg::DATA_W'(out_data.count));
        if (out_data.is_empty !== oldest_rsp.is_empty)
          flag_mismatch("is_empty", ide_pkg::DATA_W'(oldest_rsp.is_empty),
                        ide_pkg::DATA_W'(out_data.is_empty));
      end
    end
  end

  // Main sequence
  initial begin
    burst_t kind;
    int burst_len;
    int sent;
    ide_pkg::req_t r;

    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    shadow_fill = 0;
    for (int i = 0; i < DEPTH; i++) shadow_slots[i] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening sequence: empty list, bad indexes, spare codes, extreme values
    foreach (opening_script[i])
      send_request(opening_script[i].req, opening_script[i].hand_checked, opening_script[i].rsp);

    // Random bursts, cycling through the idle and back-pressure mixes
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 81; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 81; end
        default: begin idle_pct = 37; stall_pct <= 37; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = burst_t'($urandom_range(9) < 4 ? BURST_FILL :
                        $urandom_range(5) < 3 ? BURST_DRAIN :
                        $urandom_range(3) < 3 ? BURST_MIX : BURST_NOISE);
        case (kind)
          BURST_FILL:  burst_len = DEPTH - shadow_fill + $urandom_range(3);
          BURST_DRAIN: burst_len = shadow_fill + $urandom_range(3);
          BURST_MIX:   burst_len = $urandom_range(20, 3);
          default:     burst_len = $urandom_range(6, 1);
        endcase
        repeat (burst_len) begin
          r = draw_request(kind);
          send_request(r, 1'b0, '0);
          if (r.func <= ide_pkg::FN_ERASE) sent++;
        end
      end
    end

    // Drain and let any stray result show up
    in_valid <= 1'b0;
    stall_pct <= 0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_indexed_deque_engine OK");
    end else begin
      $display("tb_indexed_deque_engine NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("%0t: timeout, %0d results still outstanding", $time, pending_rsps.size());
    $display("tb_indexed_deque_engine NOT OK");
    $finish;
  end

endmodule
